/* rtl/rypr_pkg.sv */
// Shared types, constants and arithmetic helpers for the rotation-to-Euler converter.
`default_nettype none
package rypr_pkg;

    // Datapath width for the scaled matrix entries and CORDIC vectors.
    localparam int W = 34;
    // Angle accumulator width, in units of 2^-16 degree.
    localparam int ZW = 26;
    // Product width for the gain correction.
    localparam int PW = 66;
    // Field widths.
    localparam int IW = 16;
    localparam int OW = 16;
    // Defaults and fixed constants.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ENTRY_SHIFT = 14;
    localparam int GAIN_SHIFT = 30;
    localparam logic signed [PW-1:0] INV_GAIN_Q30 = 66'sd652032874;
    localparam logic signed [ZW-1:0] HALF_TURN = 26'sd11796480;
    localparam logic signed [ZW:0] ROUND_HALF = 27'sd256;
    localparam int OUT_SHIFT = 9;
    localparam logic signed [ZW:0] ANGLE_LIMIT = 27'sd23040;

    // State of one vectoring CORDIC with two companion pairs.
    typedef struct packed {
        logic hold;
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [ZW-1:0] z;
        logic signed [W-1:0] c0x;
        logic signed [W-1:0] c0y;
        logic signed [W-1:0] c1x;
        logic signed [W-1:0] c1y;
    } vec_t;

    // atan(2^-i) in units of 2^-16 degree.
    function automatic logic signed [ZW-1:0] atan_val(input int unsigned i);
        logic signed [ZW-1:0] a;
        unique case (i)
            0: a = 26'sd2949120;
            1: a = 26'sd1740967;
            2: a = 26'sd919879;
            3: a = 26'sd466945;
            4: a = 26'sd234379;
            5: a = 26'sd117304;
            6: a = 26'sd58666;
            7: a = 26'sd29335;
            8: a = 26'sd14668;
            9: a = 26'sd7334;
            10: a = 26'sd3667;
            11: a = 26'sd1833;
            12: a = 26'sd917;
            13: a = 26'sd458;
            14: a = 26'sd229;
            15: a = 26'sd115;
            16: a = 26'sd57;
            17: a = 26'sd29;
            18: a = 26'sd14;
            19: a = 26'sd7;
            20: a = 26'sd4;
            21: a = 26'sd2;
            22: a = 26'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

    // Set up a vectoring run: a zero vector freezes the run at angle zero,
    // and a vector in the left half plane is turned by 180 degrees first.
    function automatic vec_t prep(input logic signed [W-1:0] x, input logic signed [W-1:0] y,
                                  input logic signed [W-1:0] c0x,
                                  input logic signed [W-1:0] c0y,
                                  input logic signed [W-1:0] c1x,
                                  input logic signed [W-1:0] c1y);
        vec_t v;
        v.hold = (x == '0) && (y == '0);
        v.x = x;
        v.y = y;
        v.z = '0;
        v.c0x = c0x;
        v.c0y = c0y;
        v.c1x = c1x;
        v.c1y = c1y;
        if (x < 0)
        begin
            v.z = (y >= 0) ? HALF_TURN : -HALF_TURN;
            v.x = -x;
            v.y = -y;
            v.c0x = -c0x;
            v.c0y = -c0y;
            v.c1x = -c1x;
            v.c1y = -c1y;
        end
        return v;
    endfunction

    // Round to the nearest 1/128 degree, ties up, and saturate to +-180 degrees.
    function automatic logic signed [OW-1:0] to_out(input logic signed [ZW-1:0] z);
        logic signed [ZW:0] t;
        logic signed [ZW:0] r;
        t = (ZW+1)'(z) + ROUND_HALF;
        r = t >>> OUT_SHIFT;
        if (r > ANGLE_LIMIT)
        begin
            r = ANGLE_LIMIT;
        end
        else if (r < -ANGLE_LIMIT)
        begin
            r = -ANGLE_LIMIT;
        end
        return r[OW-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/rypr_cell.sv */
// One CORDIC micro-rotation cell that rotates the vector and its companions.
`default_nettype none
module rypr_cell #(
    parameter int STEP = 0,
    parameter int AUX_W = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 valid_in,
    input  wire rypr_pkg::vec_t v_in,
    input  wire [AUX_W-1:0]     aux_in,
    output logic                valid_out,
    output rypr_pkg::vec_t      v_out,
    output logic [AUX_W-1:0]    aux_out
);

    logic valid_reg;
    rypr_pkg::vec_t v_reg, v_next;
    logic [AUX_W-1:0] aux_reg;

    // Turn toward the x axis by atan(2^-STEP); a held vector passes unchanged.
    always_comb
    begin
        v_next = v_in;
        if (!v_in.hold)
        begin
            if (v_in.y >= 0)
            begin
                v_next.x = v_in.x + (v_in.y >>> STEP);
                v_next.y = v_in.y - (v_in.x >>> STEP);
                v_next.z = v_in.z + rypr_pkg::atan_val(STEP);
                v_next.c0x = v_in.c0x + (v_in.c0y >>> STEP);
                v_next.c0y = v_in.c0y - (v_in.c0x >>> STEP);
                v_next.c1x = v_in.c1x + (v_in.c1y >>> STEP);
                v_next.c1y = v_in.c1y - (v_in.c1x >>> STEP);
            end
            else
            begin
                v_next.x = v_in.x - (v_in.y >>> STEP);
                v_next.y = v_in.y + (v_in.x >>> STEP);
                v_next.z = v_in.z - rypr_pkg::atan_val(STEP);
                v_next.c0x = v_in.c0x - (v_in.c0y >>> STEP);
                v_next.c0y = v_in.c0y + (v_in.c0x >>> STEP);
                v_next.c1x = v_in.c1x - (v_in.c1y >>> STEP);
                v_next.c1y = v_in.c1y + (v_in.c1x >>> STEP);
            end
        end
    end

    // Control bit under reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        aux_reg <= aux_in;
    end

    assign valid_out = valid_reg;
    assign v_out = v_reg;
    assign aux_out = aux_reg;

endmodule
`default_nettype wire

/* rtl/rypr_chain.sv */
// A row of CORDIC cells, one per step, forming a full vectoring run.
`default_nettype none
module rypr_chain #(
    parameter int STEPS = rypr_pkg::CORDIC_STEPS_DEF,
    parameter int AUX_W = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 valid_in,
    input  wire rypr_pkg::vec_t v_in,
    input  wire [AUX_W-1:0]     aux_in,
    output logic                valid_out,
    output rypr_pkg::vec_t      v_out,
    output logic [AUX_W-1:0]    aux_out
);

    logic valid_tap [0:STEPS];
    rypr_pkg::vec_t v_tap [0:STEPS];
    logic [AUX_W-1:0] aux_tap [0:STEPS];

    assign valid_tap[0] = valid_in;
    assign v_tap[0] = v_in;
    assign aux_tap[0] = aux_in;

    // Each cell hands its vector to the next one every cycle.
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        rypr_cell #(
            .STEP (i),
            .AUX_W(AUX_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .valid_in (valid_tap[i]),
            .v_in     (v_tap[i]),
            .aux_in   (aux_tap[i]),
            .valid_out(valid_tap[i+1]),
            .v_out    (v_tap[i+1]),
            .aux_out  (aux_tap[i+1])
        );
    end

    assign valid_out = valid_tap[STEPS];
    assign v_out = v_tap[STEPS];
    assign aux_out = aux_tap[STEPS];

endmodule
`default_nettype wire

/* rtl/rotation_to_yaw_pitch_roll.sv */
// Top level: rotation matrix to Z-Y-X Euler angles through pipelined CORDIC chains.
//
//  channel   handshake          payload
//  input     start / busy       r00 r10 r20 r01 r11 r02 r12 (Q2.14)
//  output    done (strobe)      yaw_deg pitch_deg roll_deg (1/128 degree)
//
// One matrix may be started every cycle; busy is always low.
// Stages in order: input register, yaw chain, gain multiply, pitch/roll
// setup, the pitch and roll chains side by side, output.
// Reset clears only the valid bits along the pipeline.
// Each result beat shows on done for one cycle; the receiver cannot stall.
`default_nettype none
module rotation_to_yaw_pitch_roll #(
    parameter int CORDIC_STEPS = rypr_pkg::CORDIC_STEPS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire signed [rypr_pkg::IW-1:0]       r00,
    input  wire signed [rypr_pkg::IW-1:0]       r10,
    input  wire signed [rypr_pkg::IW-1:0]       r20,
    input  wire signed [rypr_pkg::IW-1:0]       r01,
    input  wire signed [rypr_pkg::IW-1:0]       r11,
    input  wire signed [rypr_pkg::IW-1:0]       r02,
    input  wire signed [rypr_pkg::IW-1:0]       r12,
    output logic                                done,
    output logic signed [rypr_pkg::OW-1:0]      yaw_deg,
    output logic signed [rypr_pkg::OW-1:0]      pitch_deg,
    output logic signed [rypr_pkg::OW-1:0]      roll_deg
);

    localparam int W = rypr_pkg::W;
    localparam int IW = rypr_pkg::IW;
    localparam int OW = rypr_pkg::OW;
    localparam int HW = OW / 2;
    localparam int LATENCY = 2 * CORDIC_STEPS + 4;

    // Input stage.
    logic in_valid_reg;
    rypr_pkg::vec_t in_vec_reg, in_vec_next;
    logic [IW-1:0] in_r20_reg;

    // Yaw chain outputs.
    logic yaw_valid;
    rypr_pkg::vec_t yaw_vec;
    logic [IW-1:0] yaw_r20;

    // Gain correction stage.
    logic mul_valid_reg;
    logic signed [rypr_pkg::PW-1:0] prod_reg, prod_next;
    logic signed [OW-1:0] yaw_q_reg;
    logic signed [IW-1:0] mul_r20_reg;
    logic signed [W-1:0] mul_cy0_reg;
    logic signed [W-1:0] mul_cy1_reg;

    // Pitch/roll setup stage.
    logic pr_valid_reg;
    rypr_pkg::vec_t pitch_in_reg, pitch_in_next;
    rypr_pkg::vec_t roll_in_reg, roll_in_next;
    logic signed [OW-1:0] pr_yaw_reg;
    logic signed [W-1:0] h_val;

    // Pitch and roll chain outputs.
    logic pitch_valid, roll_valid;
    rypr_pkg::vec_t pitch_vec, roll_vec;
    logic [HW-1:0] yaw_hi, yaw_lo;

    // Output stage.
    logic done_reg;
    logic signed [OW-1:0] yaw_out_reg, pitch_out_reg, roll_out_reg;

    assign busy = 1'b0;

    // Scale the entries to 2^28 per unit and set up the yaw run.
    always_comb
    begin
        in_vec_next = rypr_pkg::prep(W'(r00) <<< rypr_pkg::ENTRY_SHIFT,
                                     W'(r10) <<< rypr_pkg::ENTRY_SHIFT,
                                     W'(r01) <<< rypr_pkg::ENTRY_SHIFT,
                                     W'(r11) <<< rypr_pkg::ENTRY_SHIFT,
                                     W'(r02) <<< rypr_pkg::ENTRY_SHIFT,
                                     W'(r12) <<< rypr_pkg::ENTRY_SHIFT);
    end

    rypr_chain #(
        .STEPS(CORDIC_STEPS),
        .AUX_W(IW)
    ) u_yaw_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (in_valid_reg),
        .v_in     (in_vec_reg),
        .aux_in   (in_r20_reg),
        .valid_out(yaw_valid),
        .v_out    (yaw_vec),
        .aux_out  (yaw_r20)
    );

    // Correct the CORDIC gain on the first column's length.
    assign prod_next = rypr_pkg::PW'(yaw_vec.x) * rypr_pkg::INV_GAIN_Q30;
    assign h_val = prod_reg[rypr_pkg::GAIN_SHIFT +: W];

    // Pitch from (h, -r20); roll from the de-yawed second and third columns.
    always_comb
    begin
        pitch_in_next = rypr_pkg::prep(h_val, -(W'(mul_r20_reg) <<< rypr_pkg::ENTRY_SHIFT),
                                       '0, '0, '0, '0);
        roll_in_next = rypr_pkg::prep(mul_cy0_reg, -mul_cy1_reg, '0, '0, '0, '0);
    end

    // The yaw result rides along, split over the two chains.
    rypr_chain #(
        .STEPS(CORDIC_STEPS),
        .AUX_W(HW)
    ) u_pitch_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (pr_valid_reg),
        .v_in     (pitch_in_reg),
        .aux_in   (pr_yaw_reg[OW-1:HW]),
        .valid_out(pitch_valid),
        .v_out    (pitch_vec),
        .aux_out  (yaw_hi)
    );

    rypr_chain #(
        .STEPS(CORDIC_STEPS),
        .AUX_W(HW)
    ) u_roll_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (pr_valid_reg),
        .v_in     (roll_in_reg),
        .aux_in   (pr_yaw_reg[HW-1:0]),
        .valid_out(roll_valid),
        .v_out    (roll_vec),
        .aux_out  (yaw_lo)
    );

    // Valid bits along the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            pr_valid_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            mul_valid_reg <= yaw_valid;
            pr_valid_reg <= mul_valid_reg;
            done_reg <= pitch_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        in_vec_reg <= in_vec_next;
        in_r20_reg <= r20;
        prod_reg <= prod_next;
        yaw_q_reg <= rypr_pkg::to_out(yaw_vec.z);
        mul_r20_reg <= yaw_r20;
        mul_cy0_reg <= yaw_vec.c0y;
        mul_cy1_reg <= yaw_vec.c1y;
        pitch_in_reg <= pitch_in_next;
        roll_in_reg <= roll_in_next;
        pr_yaw_reg <= yaw_q_reg;
        yaw_out_reg <= {yaw_hi, yaw_lo};
        pitch_out_reg <= rypr_pkg::to_out(pitch_vec.z);
        roll_out_reg <= rypr_pkg::to_out(roll_vec.z);
    end

    assign done = done_reg;
    assign yaw_deg = yaw_out_reg;
    assign pitch_deg = pitch_out_reg;
    assign roll_deg = roll_out_reg;

    // Every started matrix gives its result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("result beat missing after fixed latency");

    // The pitch and roll chains stay in lockstep.
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        pitch_valid == roll_valid)
        else $error("pitch and roll chains out of step");

    // Delivered angles stay within +-180 degrees.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (yaw_deg >= -16'sd23040 && yaw_deg <= 16'sd23040
                  && pitch_deg >= -16'sd23040 && pitch_deg <= 16'sd23040
                  && roll_deg >= -16'sd23040 && roll_deg <= 16'sd23040))
        else $error("angle out of range");

endmodule
`default_nettype wire
